// File: design/aee_pkg.sv
// Package with the shared constants of the activity energy estimator.
`default_nettype none
package aee_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_HEIGHT = 2'd0;
  localparam logic [1:0] REG_WEIGHT = 2'd1;
  localparam logic [1:0] REG_AGE    = 2'd2;
  localparam logic [1:0] REG_SEX    = 2'd3;

  // Sex codes.
  localparam logic [1:0] SEX_MALE   = 2'd0;
  localparam logic [1:0] SEX_FEMALE = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [11:0] HEIGHT_RST = 12'd1700;
  localparam logic [15:0] WEIGHT_RST = 16'd7000;
  localparam logic [7:0]  AGE_RST    = 8'd30;
  localparam logic [1:0]  SEX_RST    = 2'd2;

  // Stride: 31 * 60000 per step and minute, plus the base stride.
  localparam logic [20:0] STRIDE_K    = 21'd1860000;
  localparam logic [10:0] STRIDE_BASE = 11'd1449;

  // Distance rounding and saturation.
  localparam logic [13:0] DIST_DEN  = 14'd10000;
  localparam logic [12:0] DIST_HALF = 13'd5000;
  localparam logic [45:0] DIST_SAT  = 46'd42949672955000;

  // Rate check: rate > 120000 mm/min means dist*60000 >= 120001*ms.
  localparam logic [15:0] MS_PER_MIN = 16'd60000;
  localparam logic [16:0] RUN_LIMIT  = 17'd120001;

  // Activity factors and rounding by 1e8.
  localparam logic [9:0]  K_WALK   = 10'd501;
  localparam logic [9:0]  K_RUN    = 10'd1002;
  localparam logic [26:0] ACT_DEN  = 27'd100000000;
  localparam logic [25:0] ACT_HALF = 26'd50000000;

  // Mifflin-St Jeor terms, scaled by 1000.
  localparam logic [6:0]  MSJ_WEIGHT = 7'd100;
  localparam logic [9:0]  MSJ_HEIGHT = 10'd625;
  localparam logic [12:0] MSJ_AGE    = 13'd5000;
  localparam logic [12:0] MSJ_MALE   = 13'd5000;
  localparam logic [17:0] MSJ_FEMALE = 18'd161000;
  localparam logic [17:0] MSJ_OTHER  = 18'd78000;

  localparam logic [10:0] DAY_MIN      = 11'd1440;
  localparam logic [9:0]  DAY_MIN_HALF = 10'd720;
  localparam logic [22:0] REST_MAX     = 23'h7FFFFF;

  // Truncated reciprocals for the constant divisions. Each one is applied to
  // the upper 32 bits of its numerator and never overestimates the quotient.
  localparam logic [31:0] DIST_RCP = 32'((64'd1 << 45) / 64'd10000);
  localparam logic [31:0] ACT_RCP  = 32'((64'd1 << 58) / 64'd100000000);
  localparam logic [31:0] REST_RCP = 32'((64'd1 << 42) / 64'd1440);

endpackage
`default_nettype wire

// File: design/aee_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module aee_div #(
  parameter int NW = 37,
  parameter int DW = 27,
  parameter int QW = 37,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_vld,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_vld,
  output logic [QW-1:0]      out_quot,
  output logic [SW-1:0]      out_side
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld_r  [QW];
  logic [NW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quot_r [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stg
    logic          vld_i;
    logic [NW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] quot_i;
    logic [SW-1:0] side_i;
    logic [CW-1:0] dsh;
    logic [CW-1:0] rem_x;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = in_num;
      assign den_i  = in_den;
      assign quot_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign den_i  = den_r[k-1];
      assign quot_i = quot_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign dsh   = CW'(den_i) << (QW - 1 - k);
    assign rem_x = CW'(rem_i);
    assign ge    = rem_x >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? NW'(rem_x - dsh) : rem_i;
      den_r[k]  <= den_i;
      quot_r[k] <= ge ? (quot_i | (QW'(1) << (QW - 1 - k))) : quot_i;
      side_r[k] <= side_i;
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_quot = quot_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule
`default_nettype wire

// File: design/activity_energy_estimator.sv
// Top level of the activity energy estimator: distance, active and resting calories.
//
// Usage: a transaction enters when start is high while busy is low. busy is
// always low, because the pipeline takes a new transaction in every cycle.
// Each transaction produces exactly one result, shown on the out_ ports for
// one cycle while out_valid is high. The receiver cannot stall the block.
// Throughput is one transaction per cycle. Most of the pipeline is the
// 37-stage divider for the stride (divided by the interval). Thirteen more
// stages carry the arithmetic: the constant divisions by 10000, 1e8 and
// 1440 each use a reciprocal estimate and a remainder correction over three
// stages, and the active and resting calorie divisions run side by side.
// Configuration is written through cfg_valid/cfg_ready with cfg_index
// selecting height, weight, age or sex; cfg_ready is always high. Writes
// should happen only while no transaction is in flight.
// Reset (synchronous, active low) empties the pipeline and restores the
// default user profile: 1700 mm, 70 kg, 30 years, unspecified sex.
`default_nettype none
module activity_energy_estimator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_step_count,
  input  wire logic [26:0] in_interval_ms,
  input  wire logic [10:0] in_rest_minutes,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  output logic [31:0]      out_distance_out_mm,
  output logic [31:0]      out_active_cal,
  output logic             out_is_running,
  output logic [22:0]      out_resting_cal
);

  // Configuration registers.
  logic [11:0] height_r;
  logic [15:0] weight_r;
  logic [7:0]  age_r;
  logic [1:0]  sex_r;

  assign cfg_ready = 1'b1;
  // The pipeline never refuses a transaction.
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= aee_pkg::HEIGHT_RST;
      weight_r <= aee_pkg::WEIGHT_RST;
      age_r    <= aee_pkg::AGE_RST;
      sex_r    <= aee_pkg::SEX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aee_pkg::REG_HEIGHT: height_r <= cfg_data[11:0];
        aee_pkg::REG_WEIGHT: weight_r <= cfg_data;
        aee_pkg::REG_AGE:    age_r    <= cfg_data[7:0];
        aee_pkg::REG_SEX:    sex_r    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: stride numerator, 1860000 * steps + interval / 2.
  logic        v1_r;
  logic [36:0] num1_r;
  logic [54:0] side1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    num1_r  <= 37'(37'(in_step_count) * 37'(aee_pkg::STRIDE_K)) + 37'(in_interval_ms >> 1);
    side1_r <= {in_rest_minutes, in_interval_ms, in_step_count,
                (in_step_count != 16'd0) && (in_interval_ms != 27'd0)};
  end

  // Stride divider: the quotient is the cadence term of the stride.
  logic        v_d1;
  logic [36:0] q_d1;
  logic [54:0] side_d1;

  aee_div #(.NW(37), .DW(27), .QW(37), .SW(55)) u_div_stride (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v1_r),
    .in_num   (num1_r),
    .in_den   (side1_r[43:17]),
    .in_side  (side1_r),
    .out_vld  (v_d1),
    .out_quot (q_d1),
    .out_side (side_d1)
  );

  // Stage 2: stride times height.
  logic        v2_r;
  logic [48:0] sh2_r;
  logic [54:0] side2_r;
  // Stage 3: times step count, full width.
  logic        v3_r;
  logic [64:0] prod3_r;
  logic [38:0] side3_r;
  // Stage 4: saturation check and rounding half.
  logic        v4_r;
  logic [45:0] num4_r;
  logic [39:0] side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v2_r <= v_d1;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    sh2_r   <= 49'(q_d1 + 37'(aee_pkg::STRIDE_BASE)) * 49'(height_r);
    side2_r <= side_d1;
    prod3_r <= 65'(sh2_r) * 65'(side2_r[16:1]);
    // Keep rest minutes, interval and the nonzero flag.
    side3_r <= {side2_r[54:17], side2_r[0]};
    // A product this large rounds past 32 bits, so the distance saturates.
    if (prod3_r >= 65'(aee_pkg::DIST_SAT)) begin
      num4_r <= '0;
      side4_r <= {side3_r, 1'b1};
    end else begin
      num4_r <= prod3_r[45:0] + 46'(aee_pkg::DIST_HALF);
      side4_r <= {side3_r, 1'b0};
    end
  end

  // Distance rounding by 10000. The reciprocal estimate from the upper 32
  // numerator bits falls short by at most four, so the remainder stays below
  // 50000 and fits in 16 bits; the next stage adds the missing multiples.
  logic        vq1_r;
  logic [31:0] dqe1_r;
  logic [15:0] dlow_r;
  logic [39:0] dside1_r;
  logic        vq2_r;
  logic [31:0] dqe2_r;
  logic [15:0] drem_r;
  logic [39:0] dside2_r;
  logic [2:0]  dfix_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq1_r <= 1'b0;
      vq2_r <= 1'b0;
    end else begin
      vq1_r <= v4_r;
      vq2_r <= vq1_r;
    end
  end

  always_ff @(posedge clk) begin
    dqe1_r   <= 32'((64'(num4_r[45:14]) * 64'(aee_pkg::DIST_RCP)) >> 31);
    dlow_r   <= num4_r[15:0];
    dside1_r <= side4_r;
    dqe2_r   <= dqe1_r;
    drem_r   <= dlow_r - 16'(dqe1_r[15:0] * 16'(aee_pkg::DIST_DEN));
    dside2_r <= dside1_r;
  end

  assign dfix_nxt = 3'(drem_r >= 16'(aee_pkg::DIST_DEN))
                  + 3'(drem_r >= 16'(aee_pkg::DIST_DEN * 2))
                  + 3'(drem_r >= 16'(aee_pkg::DIST_DEN * 3))
                  + 3'(drem_r >= 16'(aee_pkg::DIST_DEN * 4));

  // Stage 5: final distance.
  logic        v5_r;
  logic [31:0] dist5_r;
  logic [37:0] side5_r;

  // Stage 6: products for the rate check and the active calories.
  logic        v6_r;
  logic [31:0] dist6_r;
  logic [47:0] rate6_r;
  logic [43:0] lim6_r;
  logic [47:0] dw6_r;
  logic [10:0] min6_r;

  // Stage 7: walking or running decision and daily resting rate.
  logic        v7_r;
  logic [31:0] dist7_r;
  logic [47:0] dw7_r;
  logic        run7_r;
  logic [23:0] pd7_r;
  logic [10:0] min7_r;

  // Stage 8: division numerators.
  logic        v8_r;
  logic [31:0] dist8_r;
  logic        run8_r;
  logic [57:0] anum8_r;
  logic [34:0] rnum8_r;

  logic [23:0] pos_nxt;
  logic [21:0] neg_nxt;
  logic [23:0] pd_nxt;

  // Mifflin-St Jeor per day, scaled by 1000, clamped at zero.
  always_comb begin
    pos_nxt = 24'(24'(weight_r) * 24'(aee_pkg::MSJ_WEIGHT))
            + 24'(24'(height_r) * 24'(aee_pkg::MSJ_HEIGHT));
    neg_nxt = 22'(22'(age_r) * 22'(aee_pkg::MSJ_AGE));
    unique case (sex_r)
      aee_pkg::SEX_MALE:   pos_nxt = pos_nxt + 24'(aee_pkg::MSJ_MALE);
      aee_pkg::SEX_FEMALE: neg_nxt = neg_nxt + 22'(aee_pkg::MSJ_FEMALE);
      default:             neg_nxt = neg_nxt + 22'(aee_pkg::MSJ_OTHER);
    endcase
    pd_nxt = (pos_nxt > 24'(neg_nxt)) ? (pos_nxt - 24'(neg_nxt)) : 24'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      v5_r <= vq2_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    // dside2_r: minutes, interval, nonzero flag, saturation flag.
    if (!dside2_r[1]) begin
      dist5_r <= '0;
    end else if (dside2_r[0]) begin
      dist5_r <= 32'hFFFF_FFFF;
    end else begin
      dist5_r <= dqe2_r + 32'(dfix_nxt);
    end
    side5_r <= dside2_r[39:2];

    dist6_r <= dist5_r;
    rate6_r <= 48'(dist5_r) * 48'(aee_pkg::MS_PER_MIN);
    lim6_r  <= 44'(side5_r[26:0]) * 44'(aee_pkg::RUN_LIMIT);
    dw6_r   <= 48'(dist5_r) * 48'(weight_r);
    min6_r  <= side5_r[37:27];

    // A nonzero distance implies a nonzero interval.
    dist7_r <= dist6_r;
    dw7_r   <= dw6_r;
    run7_r  <= (dist6_r != 32'd0) && (rate6_r >= 48'(lim6_r));
    pd7_r   <= pd_nxt;
    min7_r  <= min6_r;

    dist8_r <= dist7_r;
    run8_r  <= run7_r;
    anum8_r <= 58'(58'(dw7_r) * 58'(run7_r ? aee_pkg::K_RUN : aee_pkg::K_WALK))
             + 58'(aee_pkg::ACT_HALF);
    rnum8_r <= 35'(35'(pd7_r) * 35'(min7_r)) + 35'(aee_pkg::DAY_MIN_HALF);
  end

  // Active calories (by 1e8) and resting calories (by 1440) are divided side
  // by side. The estimates fall short by at most two and one, respectively.
  logic        vc1_r;
  logic [31:0] aqe1_r;
  logic [28:0] alow_r;
  logic [24:0] rqe1_r;
  logic [11:0] rlow_r;
  logic [31:0] dist9_r;
  logic        run9_r;
  logic        vc2_r;
  logic [31:0] aqe2_r;
  logic [28:0] arem_r;
  logic [24:0] rqe2_r;
  logic [11:0] rrem_r;
  logic [31:0] dist10_r;
  logic        run10_r;
  logic [1:0]  afix_nxt;
  logic [24:0] rest_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc1_r <= 1'b0;
      vc2_r <= 1'b0;
    end else begin
      vc1_r <= v8_r;
      vc2_r <= vc1_r;
    end
  end

  always_ff @(posedge clk) begin
    aqe1_r   <= 32'((64'(anum8_r[57:26]) * 64'(aee_pkg::ACT_RCP)) >> 32);
    alow_r   <= anum8_r[28:0];
    rqe1_r   <= 25'((64'(rnum8_r[34:3]) * 64'(aee_pkg::REST_RCP)) >> 39);
    rlow_r   <= rnum8_r[11:0];
    dist9_r  <= dist8_r;
    run9_r   <= run8_r;

    aqe2_r   <= aqe1_r;
    arem_r   <= alow_r - 29'(aqe1_r[28:0] * 29'(aee_pkg::ACT_DEN));
    rqe2_r   <= rqe1_r;
    rrem_r   <= rlow_r - 12'(rqe1_r[11:0] * 12'(aee_pkg::DAY_MIN));
    dist10_r <= dist9_r;
    run10_r  <= run9_r;
  end

  assign afix_nxt = 2'(arem_r >= 29'(aee_pkg::ACT_DEN))
                  + 2'(arem_r >= 29'(aee_pkg::ACT_DEN * 2));
  assign rest_nxt = rqe2_r + 25'(rrem_r >= 12'(aee_pkg::DAY_MIN));

  // Output register: one strobe per transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vc2_r;
    end
  end

  always_ff @(posedge clk) begin
    out_distance_out_mm <= dist10_r;
    out_active_cal      <= aqe2_r + 32'(afix_nxt);
    out_is_running      <= run10_r;
    out_resting_cal     <= (rest_nxt > 25'(aee_pkg::REST_MAX)) ? aee_pkg::REST_MAX
                                                               : rest_nxt[22:0];
  end

endmodule
`default_nettype wire

// File: bench/activity_energy_estimator_test.sv
// Self-checking testbench for the activity energy estimator.
`default_nettype none
module activity_energy_estimator_test;

  // One expected or observed result: distance, active calories, gait and
  // resting calories.
  typedef struct packed {
    logic [31:0] distance;
    logic [31:0] calories;
    logic        running;
    logic [22:0] resting_cal;
  } energy_result_t;

  // The scoreboard keeps its own copy of the user profile and computes the
  // expected result for every accepted transaction. Expectations are held in
  // arrival order, because the block answers every transaction in order.
  class energy_scoreboard;
    logic [11:0] prof_height;
    logic [15:0] prof_weight;
    logic [7:0]  prof_age;
    logic [1:0]  sex;
    energy_result_t pending[$];
    int unsigned mismatches;

    function new();
      prof_height = aee_pkg::HEIGHT_RST;
      prof_weight = aee_pkg::WEIGHT_RST;
      prof_age    = aee_pkg::AGE_RST;
      sex         = aee_pkg::SEX_RST;
      mismatches  = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [15:0] value);
      case (index)
        aee_pkg::REG_HEIGHT: prof_height = value[11:0];
        aee_pkg::REG_WEIGHT: prof_weight = value;
        aee_pkg::REG_AGE:    prof_age    = value[7:0];
        aee_pkg::REG_SEX:    sex         = value[1:0];
        default: ;
      endcase
    endfunction

    // Distance in millimeters. The stride product is formed in 128 bits so
    // that a product beyond 64 bits saturates, as the block specifies.
    function logic [31:0] distance_of(longint unsigned steps, longint unsigned ms);
      longint unsigned stride;
      logic [127:0] product;
      logic [127:0] rounded;
      if (steps == 0 || ms == 0) return 32'd0;
      stride  = (64'd31 * steps * 64'd60000 + ms / 2) / ms + 64'd1449;
      product = 128'(stride) * 128'(prof_height) * 128'(steps);
      if (product > 128'(64'hFFFF_FFFF_FFFF_FFFF - 64'd5000)) return 32'hFFFF_FFFF;
      rounded = (product + 128'd5000) / 128'd10000;
      return (rounded > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : rounded[31:0];
    endfunction

    function longint unsigned resting_of(longint unsigned minutes);
      longint per_day;
      longint unsigned scaled;
      per_day = 100 * longint'(prof_weight) + 625 * longint'(prof_height)
              - 5000 * longint'(prof_age);
      if (sex == aee_pkg::SEX_MALE) per_day += 5000;
      else if (sex == aee_pkg::SEX_FEMALE) per_day -= 161000;
      else per_day -= 78000;
      if (per_day < 0) per_day = 0;
      scaled = (longint'(per_day) * minutes + 720) / 1440;
      return (scaled > 64'h7F_FFFF) ? 64'h7F_FFFF : scaled;
    endfunction

    function void note_reading(logic [15:0] steps, logic [26:0] ms, logic [10:0] minutes);
      energy_result_t e;
      longint unsigned dist_exp, rate, k, act;
      dist_exp = distance_of(steps, ms);
      e.distance = dist_exp[31:0];
      e.running = 1'b0;
      e.calories = 32'd0;
      if (dist_exp != 0 && ms != 0) begin
        rate = dist_exp * 64'd60000 / ms;
        e.running = rate > 64'd120000;
        k = e.running ? 64'd1002 : 64'd501;
        act = (k * dist_exp * prof_weight + 64'd50000000) / 64'd100000000;
        e.calories = (act > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : act[31:0];
      end
      e.resting_cal = 23'(resting_of(minutes));
      pending.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(energy_result_t got);
      energy_result_t want;
      if (pending.size() == 0) begin
        report("result with no transaction outstanding, distance", got.distance, 32'd0);
        return;
      end
      want = pending.pop_front();
      if (got.distance !== want.distance)
        report("distance", got.distance, want.distance);
      if (got.calories !== want.calories)
        report("active calories", got.calories, want.calories);
      if (got.running !== want.running)
        report("running flag", 32'(got.running), 32'(want.running));
      if (got.resting_cal !== want.resting_cal)
        report("resting calories", 32'(got.resting_cal), 32'(want.resting_cal));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_step_count = '0;
  logic [26:0] in_interval_ms = '0;
  logic [10:0] in_rest_minutes = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic [31:0] out_distance_out_mm;
  logic [31:0] out_active_cal;
  logic        out_is_running;
  logic [22:0] out_resting_cal;

  energy_scoreboard board;
  int unsigned cycle_count = 0;

  // The tail wait leaves a margin beyond the pipeline latency.
  localparam int unsigned TAIL_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT = 200000;

  activity_energy_estimator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_step_count(in_step_count), .in_interval_ms(in_interval_ms),
    .in_rest_minutes(in_rest_minutes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_distance_out_mm(out_distance_out_mm),
    .out_active_cal(out_active_cal), .out_is_running(out_is_running),
    .out_resting_cal(out_resting_cal)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung pipeline must not stall the run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Monitor: every accepted input transaction gets an expectation, and every
  // result strobe is checked against the oldest one. Both are sampled at the
  // rising edge, while the driver only changes inputs at the falling edge.
  always @(posedge clk) begin
    if (rst_n && board != null) begin
      if (start && !busy)
        board.note_reading(in_step_count, in_interval_ms, in_rest_minutes);
      if (out_valid)
        board.check_result({out_distance_out_mm, out_active_cal, out_is_running,
                            out_resting_cal});
    end
  end

  // Offers one transaction, first idling for a random number of cycles with
  // the given percentage, and returns at the edge that accepts it.
  task send_reading(logic [15:0] steps, logic [26:0] ms, logic [10:0] minutes,
                    int unsigned idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_step_count = steps;
    in_interval_ms = ms;
    in_rest_minutes = minutes;
    do @(posedge clk); while (busy);
  endtask

  // Waits until every expected result has come back, so the pipeline is empty.
  task drain_results();
    @(negedge clk);
    start = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the pipeline drained.
  task write_register(logic [1:0] index, logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(index, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task load_profile(logic [15:0] height, logic [15:0] weight, logic [15:0] age,
                    logic [15:0] sex);
    drain_results();
    write_register(aee_pkg::REG_HEIGHT, height);
    write_register(aee_pkg::REG_WEIGHT, weight);
    write_register(aee_pkg::REG_AGE, age);
    write_register(aee_pkg::REG_SEX, sex);
  endtask

  // Random reading. Half the intervals are realistic so that both gaits occur;
  // the rest are zero, tiny, a full day or fully random to reach saturation and every bit.
  task send_random_reading(int unsigned idle_pct);
    logic [15:0] steps;
    logic [26:0] ms;
    logic [10:0] minutes;
    case ($urandom_range(9))
      0: steps = 16'd0;
      1, 2: steps = 16'($urandom);
      3: steps = 16'hFFFF;
      default: steps = 16'($urandom_range(400));
    endcase
    case ($urandom_range(9))
      0: ms = 27'd0;
      1: ms = 27'($urandom_range(1, 100));
      2, 3: ms = 27'($urandom);
      4: ms = 27'd86400000;
      default: ms = 27'($urandom_range(1000, 600000));
    endcase
    minutes = ($urandom_range(3) == 0) ? 11'($urandom) : 11'($urandom_range(1440));
    send_reading(steps, ms, minutes, idle_pct);
  endtask

  initial begin
    int unsigned idle_pct;
    board = new();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed readings under the reset profile: field extremes, zero steps
    // and zero interval, walking and running paces.
    send_reading(16'd0, 27'd60000, 11'd1440, 0);
    send_reading(16'd100, 27'd0, 11'd0, 0);
    send_reading(16'd0, 27'd0, 11'd2047, 0);
    send_reading(16'd100, 27'd60000, 11'd720, 0);
    send_reading(16'd200, 27'd60000, 11'd60, 0);
    send_reading(16'hFFFF, 27'd1, 11'd1440, 0);
    send_reading(16'hFFFF, 27'h7FFFFFF, 11'd1, 0);
    send_reading(16'd1, 27'h7FFFFFF, 11'd1439, 0);
    send_reading(16'd1, 27'd1, 11'd1, 0);
    send_reading(16'hFFFF, 27'd86400000, 11'd1440, 0);
    send_reading(16'd5000, 27'd3600000, 11'd30, 0);

    // Tallest profile: the wide stride product saturates the distance.
    load_profile(16'd4095, 16'hFFFF, 16'd0, 16'(aee_pkg::SEX_MALE));
    send_reading(16'hFFFF, 27'd1, 11'd1440, 0);
    send_reading(16'd40000, 27'd10, 11'd2047, 0);
    send_reading(16'd150, 27'd60000, 11'd100, 0);
    // Empty profile with a high age: the daily rate goes negative and clamps.
    load_profile(16'd0, 16'd0, 16'd255, 16'(aee_pkg::SEX_FEMALE));
    send_reading(16'd300, 27'd60000, 11'd1440, 0);
    send_reading(16'd0, 27'd0, 11'd1440, 0);
    // Sex code three counts as unspecified.
    load_profile(16'd3000, 16'd50000, 16'd150, 16'd3);
    send_reading(16'd120, 27'd60000, 11'd1440, 0);
    send_reading(16'hFFFF, 27'd2, 11'd2047, 0);

    // Random phases with a fresh profile each: the sender idles 27 percent
    // of the time first, then 87 percent, then not at all. Draining before
    // every profile change also pauses the sender until all results are in.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_profile(16'd1700, 16'd7000, 16'd30, 16'd2);
        1: load_profile(16'($urandom_range(4095)), 16'($urandom), 16'($urandom_range(255)),
                        16'(aee_pkg::SEX_MALE));
        2: load_profile(16'd0, 16'd65535, 16'd0, 16'(aee_pkg::SEX_FEMALE));
        3: load_profile(16'($urandom_range(1000, 2200)), 16'($urandom_range(4000, 15000)),
                        16'($urandom_range(10, 90)), 16'd3);
        4: load_profile(16'd4095, 16'd0, 16'd255, 16'd2);
        default: load_profile(16'($urandom_range(4095)), 16'($urandom),
                              16'($urandom_range(255)), 16'($urandom_range(3)));
      endcase
      idle_pct = (phase < 2) ? 27 : (phase < 4) ? 87 : 0;
      for (int n = 0; n < 215; n++) send_random_reading(idle_pct);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: activity_energy_estimator.f
design/aee_pkg.sv
design/aee_div.sv
design/activity_energy_estimator.sv
bench/activity_energy_estimator_test.sv
